// ===== src/lsgj_pkg.sv =====
package lsgj_pkg;

	localparam int WORD_W = 32;
	localparam int THR_W = 31;
	localparam int FRAC_BITS_DEF = 16;
	localparam int LANES = 3;

	typedef enum logic [1:0] {
		ST_SOLVED    = 2'd0,
		ST_SINGULAR  = 2'd1,
		ST_SATURATED = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0][3:0][WORD_W-1:0] m;
		logic                        sat;
		logic                        sing;
	} sys_t;

endpackage

// ===== src/lsgj_div_cell.sv =====
module lsgj_div_cell #(
	parameter int NW = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  logic                                  valid_i,
	input  lsgj_pkg::sys_t                        sys_i,
	input  logic [lsgj_pkg::WORD_W-1:0]           den_i,
	input  logic [lsgj_pkg::LANES-1:0]            neg_i,
	input  logic [lsgj_pkg::LANES-1:0][NW-1:0]    num_i,
	input  logic [lsgj_pkg::LANES-1:0][lsgj_pkg::WORD_W-1:0] rem_i,
	output logic                                  valid_o,
	output lsgj_pkg::sys_t                        sys_o,
	output logic [lsgj_pkg::WORD_W-1:0]           den_o,
	output logic [lsgj_pkg::LANES-1:0]            neg_o,
	output logic [lsgj_pkg::LANES-1:0][NW-1:0]    num_o,
	output logic [lsgj_pkg::LANES-1:0][lsgj_pkg::WORD_W-1:0] rem_o
);
	import lsgj_pkg::*;

	logic [LANES-1:0][NW-1:0]     num_n;
	logic [LANES-1:0][WORD_W-1:0] rem_n;
	logic                         valid_q;
	sys_t                         sys_q;
	logic [WORD_W-1:0]            den_q;
	logic [LANES-1:0]             neg_q;
	logic [LANES-1:0][NW-1:0]     num_q;
	logic [LANES-1:0][WORD_W-1:0] rem_q;

	// One restoring quotient bit per lane.
	always_comb begin
		logic [WORD_W:0] r2;
		logic            ge;
		for (int l = 0; l < LANES; l++) begin
			r2 = {rem_i[l], num_i[l][NW-1]};
			ge = (r2 >= {1'b0, den_i});
			rem_n[l] = ge ? WORD_W'(r2 - {1'b0, den_i}) : r2[WORD_W-1:0];
			num_n[l] = {num_i[l][NW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sys_q <= sys_i;
			den_q <= den_i;
			neg_q <= neg_i;
			num_q <= num_n;
			rem_q <= rem_n;
		end
	end

	assign valid_o = valid_q;
	assign sys_o   = sys_q;
	assign den_o   = den_q;
	assign neg_o   = neg_q;
	assign num_o   = num_q;
	assign rem_o   = rem_q;

endmodule

// ===== src/lsgj_pivot_stage.sv =====
module lsgj_pivot_stage #(
	parameter int PIVOT     = 0,
	parameter int FRAC_BITS = lsgj_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic [lsgj_pkg::THR_W-1:0]   thr,
	input  logic                         valid_i,
	input  lsgj_pkg::sys_t               sys_i,
	output logic                         valid_o,
	output lsgj_pkg::sys_t               sys_o
);
	import lsgj_pkg::*;

	localparam int NW = WORD_W + FRAC_BITS;
	localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;
	localparam logic [63:0] RND = (64'(1) << FRAC_BITS) - 64'(1);
	localparam logic [NW-1:0] LIM_POS = NW'(32'h7fff_ffff);
	localparam logic [NW-1:0] LIM_NEG = NW'(33'h0_8000_0000);

	// Setup stage.
	sys_t                         setup_sys;
	logic [WORD_W-1:0]            setup_den;
	logic [LANES-1:0]             setup_neg;
	logic [LANES-1:0][NW-1:0]     setup_num;

	logic                         valid_s1;
	sys_t                         sys_s1;
	logic [WORD_W-1:0]            den_s1;
	logic [LANES-1:0]             neg_s1;
	logic [LANES-1:0][NW-1:0]     num_s1;

	always_comb begin
		logic [WORD_W-1:0] p;
		logic [WORD_W-1:0] v;
		logic [WORD_W-1:0] vmag;
		int                c;
		p = sys_i.m[PIVOT][PIVOT];
		setup_den = p[WORD_W-1] ? (~p + WORD_W'(1)) : p;
		setup_sys = sys_i;
		setup_sys.sing = sys_i.sing | (p == '0) | (setup_den < {1'b0, thr});
		for (int l = 0; l < LANES; l++) begin
			c = PIVOT + 1 + l;
			setup_num[l] = '0;
			setup_neg[l] = 1'b0;
			if (c <= 3) begin
				v = sys_i.m[PIVOT][2'(c)];
				vmag = v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
				setup_num[l] = {vmag, {FRAC_BITS{1'b0}}};
				setup_neg[l] = v[WORD_W-1] ^ p[WORD_W-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sys_s1 <= setup_sys;
			den_s1 <= setup_den;
			neg_s1 <= setup_neg;
			num_s1 <= setup_num;
		end
	end

	// Divider chain, one quotient bit per cell.
	logic                         valid_c [NW+1];
	sys_t                         sys_c   [NW+1];
	logic [WORD_W-1:0]            den_c   [NW+1];
	logic [LANES-1:0]             neg_c   [NW+1];
	logic [LANES-1:0][NW-1:0]     num_c   [NW+1];
	logic [LANES-1:0][WORD_W-1:0] rem_c   [NW+1];

	assign valid_c[0] = valid_s1;
	assign sys_c[0]   = sys_s1;
	assign den_c[0]   = den_s1;
	assign neg_c[0]   = neg_s1;
	assign num_c[0]   = num_s1;
	assign rem_c[0]   = '0;

	for (genvar g = 0; g < NW; g++) begin : g_cell
		lsgj_div_cell #(.NW(NW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.valid_i (valid_c[g]),
			.sys_i   (sys_c[g]),
			.den_i   (den_c[g]),
			.neg_i   (neg_c[g]),
			.num_i   (num_c[g]),
			.rem_i   (rem_c[g]),
			.valid_o (valid_c[g+1]),
			.sys_o   (sys_c[g+1]),
			.den_o   (den_c[g+1]),
			.neg_o   (neg_c[g+1]),
			.num_o   (num_c[g+1]),
			.rem_o   (rem_c[g+1])
		);
	end

	// Quotient sign and saturation; the pivot itself becomes one.
	sys_t fin_sys;
	logic valid_s2;
	sys_t sys_s2;

	always_comb begin
		logic [NW-1:0] q;
		logic          neg;
		logic          over;
		logic [1:0]    lane;
		fin_sys = sys_c[NW];
		fin_sys.m[PIVOT][PIVOT] = ONE;
		for (int c = 0; c < 4; c++) begin
			if (c > PIVOT) begin
				lane = 2'(c - PIVOT - 1);
				q = num_c[NW][lane];
				neg = neg_c[NW][lane] & (q != '0);
				over = neg ? (q > LIM_NEG) : (q > LIM_POS);
				if (over) begin
					fin_sys.m[PIVOT][c] = neg ? 32'h8000_0000 : 32'h7fff_ffff;
				end else begin
					fin_sys.m[PIVOT][c] = neg ? (~q[WORD_W-1:0] + WORD_W'(1)) : q[WORD_W-1:0];
				end
				fin_sys.sat = fin_sys.sat | over;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_c[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sys_s2 <= fin_sys;
		end
	end

	// Products of the row factors with the pivot row.
	logic [2:0][3:0][63:0] prod_n;
	logic                  valid_s3;
	sys_t                  sys_s3;
	logic [2:0][3:0][63:0] prod_s3;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int c = 0; c < 4; c++) begin
				prod_n[k][c] = '0;
				if (k != PIVOT && c > PIVOT) begin
					prod_n[k][c] = 64'($signed(sys_s2.m[k][PIVOT]) *
						$signed(sys_s2.m[PIVOT][c]));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sys_s3  <= sys_s2;
			prod_s3 <= prod_n;
		end
	end

	// Scale back, subtract and saturate.
	sys_t elim_sys;
	logic valid_s4;
	sys_t sys_s4;

	always_comb begin
		logic signed [63:0] t;
		logic        [63:0] biased;
		logic        [64:0] diff;
		logic               ok;
		elim_sys = sys_s3;
		for (int k = 0; k < 3; k++) begin
			if (k != PIVOT) begin
				elim_sys.m[k][PIVOT] = '0;
				for (int c = 0; c < 4; c++) begin
					if (c > PIVOT) begin
						biased = prod_s3[k][c] + (prod_s3[k][c][63] ? RND : 64'(0));
						t = $signed(biased) >>> FRAC_BITS;
						diff = 65'($signed(sys_s3.m[k][c])) - 65'(t);
						ok = (diff[64:WORD_W-1] == '0) || (diff[64:WORD_W-1] == '1);
						if (ok) begin
							elim_sys.m[k][c] = diff[WORD_W-1:0];
						end else begin
							elim_sys.m[k][c] = diff[64] ? 32'h8000_0000 : 32'h7fff_ffff;
						end
						elim_sys.sat = elim_sys.sat | ~ok;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sys_s4 <= elim_sys;
		end
	end

	assign valid_o = valid_s4;
	assign sys_o   = sys_s4;

endmodule

// ===== src/linear_solve_3x3_gauss_jordan.sv =====
// Solves a 3x3 system A x = b in signed fixed point by Gauss-Jordan elimination without
// row exchanges. A new system is taken every cycle while in_stall is low. Each of the
// three pivot stages registers a setup step, a chain of divider cells giving one quotient
// bit per cell, a sign and saturation step, a product step and an elimination step. A pivot
// whose magnitude is below cfg_data (reset 1) or that is zero gives status 1 and zero x;
// saturation anywhere in a completed solve of a nonsingular system gives status 2. The
// output has a two-entry buffer, so in_stall rises only after a result has been held back.
module linear_solve_3x3_gauss_jordan #(
	parameter int FRAC_BITS = lsgj_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lsgj_pkg::THR_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [lsgj_pkg::WORD_W-1:0] a_00,
	input  logic signed [lsgj_pkg::WORD_W-1:0] a_01,
	input  logic signed [lsgj_pkg::WORD_W-1:0] a_02,
	input  logic signed [lsgj_pkg::WORD_W-1:0] a_10,
	input  logic signed [lsgj_pkg::WORD_W-1:0] a_11,
	input  logic signed [lsgj_pkg::WORD_W-1:0] a_12,
	input  logic signed [lsgj_pkg::WORD_W-1:0] a_20,
	input  logic signed [lsgj_pkg::WORD_W-1:0] a_21,
	input  logic signed [lsgj_pkg::WORD_W-1:0] a_22,
	input  logic signed [lsgj_pkg::WORD_W-1:0] b_0,
	input  logic signed [lsgj_pkg::WORD_W-1:0] b_1,
	input  logic signed [lsgj_pkg::WORD_W-1:0] b_2,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [lsgj_pkg::WORD_W-1:0] x_0,
	output logic signed [lsgj_pkg::WORD_W-1:0] x_1,
	output logic signed [lsgj_pkg::WORD_W-1:0] x_2,
	output logic [1:0]                   status
);
	import lsgj_pkg::*;

	typedef struct packed {
		logic [2:0][WORD_W-1:0] x;
		status_t                st;
	} res_t;

	logic [THR_W-1:0] thr_q;
	logic             adv;
	sys_t             sys_in;
	logic             valid_p [4];
	sys_t             sys_p   [4];
	res_t             res_n;
	res_t             out_q;
	res_t             skid_q;
	logic             out_v_q;
	logic             skid_v_q;
	logic             take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(1);
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	assign adv      = ~skid_v_q;
	assign in_stall = skid_v_q;

	always_comb begin
		sys_in.m[0] = {b_0, a_02, a_01, a_00};
		sys_in.m[1] = {b_1, a_12, a_11, a_10};
		sys_in.m[2] = {b_2, a_22, a_21, a_20};
		sys_in.sat  = 1'b0;
		sys_in.sing = 1'b0;
	end

	assign valid_p[0] = in_valid;
	assign sys_p[0]   = sys_in;

	for (genvar g = 0; g < 3; g++) begin : g_pivot
		lsgj_pivot_stage #(.PIVOT(g), .FRAC_BITS(FRAC_BITS)) u_pivot (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.thr     (thr_q),
			.valid_i (valid_p[g]),
			.sys_i   (sys_p[g]),
			.valid_o (valid_p[g+1]),
			.sys_o   (sys_p[g+1])
		);
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res_n.x[i] = sys_p[3].sing ? '0 : sys_p[3].m[i][3];
		end
		if (sys_p[3].sing) begin
			res_n.st = ST_SINGULAR;
		end else if (sys_p[3].sat) begin
			res_n.st = ST_SATURATED;
		end else begin
			res_n.st = ST_SOLVED;
		end
	end

	assign take = out_v_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (valid_p[3]) begin
			if (out_v_q && !take) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (valid_p[3]) begin
			if (out_v_q && !take) begin
				skid_q <= res_n;
			end else begin
				out_q <= res_n;
			end
		end
	end

	assign out_valid = out_v_q;
	assign x_0       = out_q.x[0];
	assign x_1       = out_q.x[1];
	assign x_2       = out_q.x[2];
	assign status    = out_q.st;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without an output entry");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without a held result");

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_SINGULAR) |-> (x_0 == '0 && x_1 == '0 && x_2 == '0))
		else $error("singular result carries a nonzero solution");

endmodule
